/* design/spq_pkg.sv */
`default_nettype none

package spq_pkg;

    // queue geometry
    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // entry layout: priority in the upper bits, item in the lower bits
    localparam int ITEM_W  = 8;
    localparam int PRIO_W  = 4;
    localparam int ENTRY_W = PRIO_W + ITEM_W;

    localparam logic [ITEM_W-1:0] EMPTY_DATA = '1;

    // operation codes
    localparam logic FUNC_ENQ = 1'b0;
    localparam logic FUNC_DEQ = 1'b1;

    // status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic              func;
        logic [ITEM_W-1:0] item;
        logic [PRIO_W-1:0] priority_req;
    } cmd_word_t;

    typedef struct packed {
        logic [ITEM_W-1:0] data_out;
        logic [1:0]        status;
        logic              now_empty;
    } rsp_word_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEQ,
        S_SHIFT,
        S_PLACE,
        S_RESULT
    } state_t;

    typedef struct packed {
        state_t           state;
        logic [CNT_W-1:0] count;
    } ctrl_stat_t;

    // circular address: base plus offset, wrapped at the capacity
    function automatic logic [IDX_W-1:0] wrap_addr(input logic [IDX_W-1:0] base,
                                                   input logic [IDX_W-1:0] off);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (IDX_W+1)'(CAPACITY))
        begin
            sum = sum - (IDX_W+1)'(CAPACITY);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* design/spq_ram.sv */
`default_nettype none

module spq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 12
) (
    input  wire logic                                        clk,
    input  wire logic                                        we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                            wdata,
    input  wire logic                                        re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* design/spq_ctrl.sv */
`default_nettype none

module spq_ctrl (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cmd_valid,
    output logic                                 cmd_stall,
    input  wire spq_pkg::cmd_word_t              cmd,
    input  wire logic                            slot_free,
    output logic                                 res_valid,
    output spq_pkg::rsp_word_t                   res,
    output logic                                 mem_we,
    output logic [spq_pkg::IDX_W-1:0]            mem_waddr,
    output logic [spq_pkg::ENTRY_W-1:0]          mem_wdata,
    output logic                                 mem_re,
    output logic [spq_pkg::IDX_W-1:0]            mem_raddr,
    input  wire logic [spq_pkg::ENTRY_W-1:0]     mem_rdata,
    output spq_pkg::ctrl_stat_t                  stat
);

    spq_pkg::state_t                  state_reg, state_next;
    logic [spq_pkg::IDX_W-1:0]        head_reg, head_next;
    logic [spq_pkg::CNT_W-1:0]        count_reg, count_next;
    logic [spq_pkg::IDX_W-1:0]        pos_reg, pos_next;
    logic [spq_pkg::ENTRY_W-1:0]      new_entry_reg, new_entry_next;
    spq_pkg::rsp_word_t               res_reg, res_next;

    logic                             fin;
    spq_pkg::rsp_word_t               fin_word;
    logic [spq_pkg::ENTRY_W-1:0]      cmd_entry;
    logic                             shift_up;

    assign cmd_entry = {cmd.priority_req, cmd.item};
    assign shift_up  = mem_rdata[spq_pkg::ENTRY_W-1:spq_pkg::ITEM_W]
                       > new_entry_reg[spq_pkg::ENTRY_W-1:spq_pkg::ITEM_W];
    assign cmd_stall = (state_reg != spq_pkg::S_IDLE);

    assign stat.state = state_reg;
    assign stat.count = count_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spq_pkg::S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        new_entry_reg <= new_entry_next;
        res_reg       <= res_next;
    end

    // sequencer: insertion walks from the tail toward the head, one entry a cycle
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        new_entry_next = new_entry_reg;
        res_next       = res_reg;
        mem_we         = 1'b0;
        mem_waddr      = spq_pkg::wrap_addr(head_reg, pos_reg);
        mem_wdata      = new_entry_reg;
        mem_re         = 1'b0;
        mem_raddr      = head_reg;
        res_valid      = 1'b0;
        res            = res_reg;
        fin            = 1'b0;
        fin_word       = '{data_out: '0, status: spq_pkg::STAT_OK, now_empty: 1'b0};

        case (state_reg)
            spq_pkg::S_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.func == spq_pkg::FUNC_DEQ)
                    begin
                        if (count_reg == '0)
                        begin
                            fin      = 1'b1;
                            fin_word = '{data_out: spq_pkg::EMPTY_DATA,
                                         status: spq_pkg::STAT_EMPTY, now_empty: 1'b1};
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = head_reg;
                            state_next = spq_pkg::S_DEQ;
                        end
                    end
                    else if (count_reg == spq_pkg::CNT_W'(spq_pkg::CAPACITY))
                    begin
                        fin      = 1'b1;
                        fin_word = '{data_out: '0, status: spq_pkg::STAT_FULL,
                                     now_empty: 1'b0};
                    end
                    else
                    begin
                        new_entry_next = cmd_entry;
                        if (count_reg == '0)
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = head_reg;
                            mem_wdata  = cmd_entry;
                            count_next = count_reg + 1'b1;
                            fin        = 1'b1;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = spq_pkg::wrap_addr(head_reg,
                                             count_reg[spq_pkg::IDX_W-1:0] - 1'b1);
                            pos_next   = count_reg[spq_pkg::IDX_W-1:0];
                            state_next = spq_pkg::S_SHIFT;
                        end
                    end
                end
            end

            spq_pkg::S_DEQ:
            begin
                head_next  = spq_pkg::wrap_addr(head_reg, spq_pkg::IDX_W'(1));
                count_next = count_reg - 1'b1;
                fin        = 1'b1;
                fin_word   = '{data_out: mem_rdata[spq_pkg::ITEM_W-1:0],
                               status: spq_pkg::STAT_OK,
                               now_empty: (count_reg == spq_pkg::CNT_W'(1))};
            end

            spq_pkg::S_SHIFT:
            begin
                mem_we = 1'b1;
                if (shift_up)
                begin
                    // move the less urgent entry one place toward the tail
                    mem_wdata = mem_rdata;
                    pos_next  = pos_reg - 1'b1;
                    if (pos_reg == spq_pkg::IDX_W'(1))
                    begin
                        state_next = spq_pkg::S_PLACE;
                    end
                    else
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = spq_pkg::wrap_addr(head_reg, pos_reg - spq_pkg::IDX_W'(2));
                    end
                end
                else
                begin
                    mem_wdata  = new_entry_reg;
                    count_next = count_reg + 1'b1;
                    fin        = 1'b1;
                end
            end

            spq_pkg::S_PLACE:
            begin
                mem_we     = 1'b1;
                mem_wdata  = new_entry_reg;
                count_next = count_reg + 1'b1;
                fin        = 1'b1;
            end

            spq_pkg::S_RESULT:
            begin
                res_valid = 1'b1;
                if (slot_free)
                begin
                    state_next = spq_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = spq_pkg::S_IDLE;
            end
        endcase

        // hand the finished word to the output, or park it
        if (fin)
        begin
            res_valid  = 1'b1;
            res        = fin_word;
            res_next   = fin_word;
            state_next = slot_free ? spq_pkg::S_IDLE : spq_pkg::S_RESULT;
        end
    end

endmodule

`default_nettype wire

/* design/stable_priority_queue.sv */
// A dequeue from an empty queue, and an enqueue into a full or empty queue, finish without a memory read.
// A dequeue makes one memory read. An enqueue into a non-empty queue reads the tail entry, then
// moves each less urgent entry one place toward the tail before writing the new entry.
// One word at a time: the next word is taken once the result has entered the output register.
// Reset clears the entry count, head pointer and control; the entry memory is not cleared.
`default_nettype none

module stable_priority_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    output logic                    cmd_stall,
    input  wire spq_pkg::cmd_word_t cmd,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output spq_pkg::rsp_word_t      rsp
);

    logic                           slot_free;
    logic                           res_valid;
    spq_pkg::rsp_word_t             res;
    logic                           mem_we;
    logic [spq_pkg::IDX_W-1:0]      mem_waddr;
    logic [spq_pkg::ENTRY_W-1:0]    mem_wdata;
    logic                           mem_re;
    logic [spq_pkg::IDX_W-1:0]      mem_raddr;
    logic [spq_pkg::ENTRY_W-1:0]    mem_rdata;
    spq_pkg::ctrl_stat_t            stat;

    logic                           rsp_valid_reg;
    spq_pkg::rsp_word_t             rsp_reg;

    assign slot_free = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // entry memory
    spq_ram #(
        .DEPTH (spq_pkg::CAPACITY),
        .WIDTH (spq_pkg::ENTRY_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // sequencer
    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .slot_free (slot_free),
        .res_valid (res_valid),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .stat      (stat)
    );

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_valid && slot_free)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // output register word
    always_ff @(posedge clk)
    begin
        if (res_valid && slot_free)
        begin
            rsp_reg <= res;
        end
    end

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stat.count <= spq_pkg::CNT_W'(spq_pkg::CAPACITY))
        else $error("entry count above capacity");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 (stat.count == $past(stat.count) || stat.count == $past(stat.count) + 1'b1
             || stat.count == $past(stat.count) - 1'b1))
        else $error("entry count moved by more than one");

    a_park_held: assert property (@(posedge clk) disable iff (!rst_n)
        stat.state == spq_pkg::S_RESULT |-> rsp_valid)
        else $error("result parked while output register empty");

    a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == spq_pkg::STAT_EMPTY
        |-> rsp.now_empty && rsp.data_out == spq_pkg::EMPTY_DATA)
        else $error("empty dequeue word malformed");

endmodule

`default_nettype wire
